/* rtl/fdr_pkg.sv */
// Package for the Fresnel dielectric reflectance unit: widths, register indexes, defaults.
package fdr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_W         = 16;
	localparam int COS_W         = 17;
	localparam int REFL_W        = 17;
	localparam int CFG_ADDR_W    = 1;

	localparam logic [IDX_W-1:0] INDEX_INC_RST = 16'd4096;
	localparam logic [IDX_W-1:0] INDEX_TRN_RST = 16'd6144;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_INDEX_INCIDENT    = 1'b0,
		REG_INDEX_TRANSMITTED = 1'b1
	} cfg_reg_t;

	// Pipeline control travelling down the cell chain.
	typedef struct packed {
		logic valid;
		logic tir;
	} fdr_ctl_t;

endpackage

/* rtl/fdr_sqrt_cell.sv */
// One cell of the pipelined restoring square root: one result bit per cell.
module fdr_sqrt_cell #(
	parameter int RW = 17,
	parameter int K  = 0
) (
	input  logic                clk,
	input  logic                en,
	input  logic [2*RW-1:0]     rem_in,
	input  logic [RW-1:0]       root_in,
	output logic [2*RW-1:0]     rem_out,
	output logic [RW-1:0]       root_out
);
	logic [2*RW+1:0] trial;
	logic [2*RW+1:0] remx;
	logic            take;

	// Trial subtract of (4*root+1) << 2K from the remainder.
	always_comb begin
		trial = ({2'b00, root_in} << (2*K + 2)) | ((2*RW+2)'(1) << (2*K));
		remx  = {2'b00, rem_in};
		take  = remx >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? (2*RW)'(remx - trial) : rem_in;
			root_out <= {root_in[RW-2:0], take};
		end
	end
endmodule

/* rtl/fdr_div_cell.sv */
// One cell of the pipelined restoring divider: one quotient bit per cell.
module fdr_div_cell #(
	parameter int DW = 32,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] den_in,
	input  logic [DW:0]   rem_in,
	input  logic [QW-1:0] quo_in,
	output logic [DW-1:0] den_out,
	output logic [DW:0]   rem_out,
	output logic [QW-1:0] quo_out
);
	logic [DW+1:0] sh;
	logic          take;

	always_comb begin
		sh   = {rem_in, 1'b0};
		take = sh >= {2'b00, den_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_out <= den_in;
			rem_out <= take ? (DW+1)'(sh - {2'b00, den_in}) : sh[DW:0];
			quo_out <= {quo_in[QW-2:0], take};
		end
	end
endmodule

/* rtl/fresnel_dielectric_reflectance_unit.sv */
// Pipeline: 2*(FRAC_BITS+1) sqrt cells, (FRAC_BITS+17) + FRAC_BITS divider cells and 8 glue
// stages lie between input transaction and result.
// Throughput: one item per cycle; the whole chain advances whenever the output register is
// free or being taken, so a stalled output stalls every cell at once.
// Reset: control valids clear; index registers return to 1.0 and 1.5 (Q4.12).
// Datapath registers are not reset.
module fresnel_dielectric_reflectance_unit #(
	parameter int FRAC_BITS = fdr_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fdr_pkg::COS_W-1:0]   cos_incidence,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fdr_pkg::REFL_W-1:0]  reflectance,
	output logic                        total_internal,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fdr_pkg::CFG_ADDR_W-1:0] cfg_index,
	input  logic [fdr_pkg::IDX_W-1:0]   cfg_data
);
	import fdr_pkg::*;

	localparam int RW  = FRAC_BITS + 1;          // angle width, holds ONE
	localparam int SW  = 2 * RW;                 // squared width
	localparam int PW  = IDX_W + RW;             // eta*cos product width
	localparam int DW  = PW + 1;                 // sum width
	localparam int QW  = FRAC_BITS + 1;          // ratio width
	localparam int SQW = 2 * QW + 1;             // sum of squares
	localparam int SH  = 2 * FRAC_BITS + 1 - 16;
	localparam int NC  = RW;                     // sqrt cells per root
	localparam logic [RW-1:0] ONE = RW'(1) << FRAC_BITS;
	localparam logic [SW-1:0] ONE_SQ = SW'(1) << (2 * FRAC_BITS);

	logic adv;
	logic [IDX_W-1:0] ei_q, et_q, ei, et;

	assign cfg_ready = 1'b1;
	assign ei = (ei_q == '0) ? IDX_W'(1) : ei_q;
	assign et = (et_q == '0) ? IDX_W'(1) : et_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ei_q <= INDEX_INC_RST;
			et_q <= INDEX_TRN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INDEX_INCIDENT:    ei_q <= cfg_data;
				REG_INDEX_TRANSMITTED: et_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: clamp and rescale cosine
	logic [RW-1:0] ci_s1;
	logic          v_s1;
	logic [COS_W-1:0] cc;
	logic [COS_W+FRAC_BITS-1:0] cw;
	always_comb begin
		cc = (cos_incidence > COS_W'(65536)) ? COS_W'(65536) : cos_incidence;
		cw = (COS_W+FRAC_BITS)'(cc) << FRAC_BITS;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) if (adv) ci_s1 <= RW'(cw >> 16);

	// Stage 2: 1 - ci^2
	logic [SW-1:0] rad_s2;
	logic [RW-1:0] ci_s2;
	logic          v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s2 <= ONE_SQ - SW'(ci_s1 * ci_s1);
			ci_s2  <= ci_s1;
		end
	end

	// First root chain: sin_i, with ci and valid carried alongside
	logic [SW-1:0] r1_rem [NC+1];
	logic [RW-1:0] r1_root[NC+1];
	logic [RW-1:0] r1_ci  [NC+1];
	logic          r1_v   [NC+1];
	assign r1_rem[0]  = rad_s2;
	assign r1_root[0] = '0;
	assign r1_ci[0]   = ci_s2;
	assign r1_v[0]    = v_s2;
	for (genvar k = 0; k < NC; k++) begin : g_sq1
		fdr_sqrt_cell #(.RW(RW), .K(NC-1-k)) u_cell (
			.clk(clk), .en(adv), .rem_in(r1_rem[k]), .root_in(r1_root[k]),
			.rem_out(r1_rem[k+1]), .root_out(r1_root[k+1]));
		always_ff @(posedge clk) if (adv) r1_ci[k+1] <= r1_ci[k];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) r1_v[k+1] <= 1'b0;
			else if (adv) r1_v[k+1] <= r1_v[k];
		end
	end

	// Stage: ei * sin_i
	logic [PW-1:0] num_s3;
	logic [RW-1:0] ci_s3;
	logic          v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= r1_v[NC];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3 <= PW'(ei * r1_root[NC]);
			ci_s3  <= r1_ci[NC];
		end
	end

	// Division chain for sin_t = num/et, carrying ci; integer quotient of PW bits
	logic [IDX_W-1:0] d0_den [PW+1];
	logic [IDX_W:0]   d0_rem [PW+1];
	logic [PW-1:0]    d0_quo [PW+1];
	logic [PW-1:0]    d0_num [PW+1];
	logic [RW-1:0]    d0_ci  [PW+1];
	logic             d0_v   [PW+1];
	assign d0_den[0] = et;
	assign d0_rem[0] = '0;
	assign d0_quo[0] = '0;
	assign d0_num[0] = num_s3;
	assign d0_ci[0]  = ci_s3;
	assign d0_v[0]   = v_s3;
	for (genvar k = 0; k < PW; k++) begin : g_dst
		logic [IDX_W+1:0] sh;
		logic             take;
		assign sh   = {d0_rem[k], d0_num[k][PW-1]};
		assign take = sh >= {2'b00, d0_den[k]};
		always_ff @(posedge clk) begin
			if (adv) begin
				d0_den[k+1] <= d0_den[k];
				d0_rem[k+1] <= take ? (IDX_W+1)'(sh - {2'b00, d0_den[k]}) : sh[IDX_W:0];
				d0_quo[k+1] <= {d0_quo[k][PW-2:0], take};
				d0_num[k+1] <= {d0_num[k][PW-2:0], 1'b0};
				d0_ci[k+1]  <= d0_ci[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d0_v[k+1] <= 1'b0;
			else if (adv) d0_v[k+1] <= d0_v[k];
		end
	end

	// Stage: TIR test and 1 - st^2
	logic [SW-1:0] rad_s4;
	logic [RW-1:0] ci_s4;
	logic          v_s4, tir_s4;
	logic          tir_c;
	assign tir_c = d0_quo[PW] >= PW'(ONE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= d0_v[PW];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			tir_s4 <= tir_c;
			ci_s4  <= d0_ci[PW];
			rad_s4 <= tir_c ? '0 : ONE_SQ - SW'(d0_quo[PW][RW-1:0] * d0_quo[PW][RW-1:0]);
		end
	end

	// Second root chain: cos_t
	logic [SW-1:0] r2_rem [NC+1];
	logic [RW-1:0] r2_root[NC+1];
	logic [RW-1:0] r2_ci  [NC+1];
	fdr_ctl_t      r2_c   [NC+1];
	assign r2_rem[0]  = rad_s4;
	assign r2_root[0] = '0;
	assign r2_ci[0]   = ci_s4;
	assign r2_c[0]    = '{valid: v_s4, tir: tir_s4};
	for (genvar k = 0; k < NC; k++) begin : g_sq2
		fdr_sqrt_cell #(.RW(RW), .K(NC-1-k)) u_cell (
			.clk(clk), .en(adv), .rem_in(r2_rem[k]), .root_in(r2_root[k]),
			.rem_out(r2_rem[k+1]), .root_out(r2_root[k+1]));
		always_ff @(posedge clk) if (adv) r2_ci[k+1] <= r2_ci[k];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) r2_c[k+1] <= '0;
			else if (adv) r2_c[k+1] <= r2_c[k];
		end
	end

	// Stage: four products
	logic [PW-1:0] p0_s5, p1_s5, p2_s5, p3_s5;
	fdr_ctl_t      c_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_s5 <= '0;
		else if (adv) c_s5 <= r2_c[NC];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s5 <= PW'(et * r2_ci[NC]);
			p1_s5 <= PW'(ei * r2_root[NC]);
			p2_s5 <= PW'(ei * r2_ci[NC]);
			p3_s5 <= PW'(et * r2_root[NC]);
		end
	end

	// Stage: abs differences and sums; integer bit of ratio (num <= den)
	logic [DW-1:0] npa_s6, dpa_s6, npe_s6, dpe_s6;
	fdr_ctl_t      c_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_s6 <= '0;
		else if (adv) c_s6 <= c_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			npa_s6 <= (p0_s5 >= p1_s5) ? DW'(p0_s5 - p1_s5) : DW'(p1_s5 - p0_s5);
			dpa_s6 <= DW'(p0_s5) + DW'(p1_s5);
			npe_s6 <= (p2_s5 >= p3_s5) ? DW'(p2_s5 - p3_s5) : DW'(p3_s5 - p2_s5);
			dpe_s6 <= DW'(p2_s5) + DW'(p3_s5);
		end
	end

	// Ratio division chains; zero denominator forces one
	logic [DW-1:0] pa_den[FRAC_BITS+1], pe_den[FRAC_BITS+1];
	logic [DW:0]   pa_rem[FRAC_BITS+1], pe_rem[FRAC_BITS+1];
	logic [QW-1:0] pa_quo[FRAC_BITS+1], pe_quo[FRAC_BITS+1];
	logic          pa_z  [FRAC_BITS+1], pe_z  [FRAC_BITS+1];
	fdr_ctl_t      dc    [FRAC_BITS+1];
	logic          pa_ge, pe_ge;
	assign pa_ge     = npa_s6 >= dpa_s6;
	assign pe_ge     = npe_s6 >= dpe_s6;
	assign pa_den[0] = dpa_s6;
	assign pe_den[0] = dpe_s6;
	assign pa_rem[0] = pa_ge ? '0 : {1'b0, npa_s6};
	assign pe_rem[0] = pe_ge ? '0 : {1'b0, npe_s6};
	assign pa_quo[0] = QW'(pa_ge);
	assign pe_quo[0] = QW'(pe_ge);
	assign pa_z[0]   = dpa_s6 == '0;
	assign pe_z[0]   = dpe_s6 == '0;
	assign dc[0]     = c_s6;
	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_rat
		fdr_div_cell #(.DW(DW), .QW(QW)) u_pa (
			.clk(clk), .en(adv), .den_in(pa_den[k]), .rem_in(pa_rem[k]), .quo_in(pa_quo[k]),
			.den_out(pa_den[k+1]), .rem_out(pa_rem[k+1]), .quo_out(pa_quo[k+1]));
		fdr_div_cell #(.DW(DW), .QW(QW)) u_pe (
			.clk(clk), .en(adv), .den_in(pe_den[k]), .rem_in(pe_rem[k]), .quo_in(pe_quo[k]),
			.den_out(pe_den[k+1]), .rem_out(pe_rem[k+1]), .quo_out(pe_quo[k+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				pa_z[k+1] <= pa_z[k];
				pe_z[k+1] <= pe_z[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dc[k+1] <= '0;
			else if (adv) dc[k+1] <= dc[k];
		end
	end

	// Stage: squares
	logic [SQW-2:0] sqa_s7, sqe_s7;
	fdr_ctl_t       c_s7;
	logic [QW-1:0]  ra, re;
	assign ra = pa_z[FRAC_BITS] ? QW'(ONE) : pa_quo[FRAC_BITS];
	assign re = pe_z[FRAC_BITS] ? QW'(ONE) : pe_quo[FRAC_BITS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_s7 <= '0;
		else if (adv) c_s7 <= dc[FRAC_BITS];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sqa_s7 <= (SQW-1)'(ra * ra);
			sqe_s7 <= (SQW-1)'(re * re);
		end
	end

	// Output register: sum, scale, saturate
	logic [SQW-1:0] sum;
	logic [SQW-1:0] scl;
	assign sum = SQW'(sqa_s7) + SQW'(sqe_s7);
	assign scl = sum >> SH;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= c_s7.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			total_internal <= c_s7.tir;
			if (c_s7.tir || scl > SQW'(65536)) reflectance <= REFL_W'(65536);
			else reflectance <= REFL_W'(scl);
		end
	end
endmodule
